// File: rtl/assert_macros.svh
// Assertion macros shared by the wheel speed RTL.
// No dependencies; compiled out when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is high
`define WSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also active during reset
`define WSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSC_ASSERT(lbl, clk, rst, prop, msg)
`define WSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/wsc_pkg.sv
// Package for the wheel speed block: item types, register indexes, datapath widths.
// No dependencies.
`default_nettype none

package wsc_pkg;

  // Divider operand widths: dividend up to 51 bits, divisor up to 44 bits
  localparam int unsigned DVD_W = 51;
  localparam int unsigned DVS_W = 44;
  localparam int unsigned Q_W   = 32;
  // Intervals wider than this give zero rpm (all ones when teeth per turn is zero)
  localparam int unsigned IVAL_W = 36;
  localparam int unsigned CNT_W  = 5;

  // 3 * (rpm sum) * circumference / 100000: km/h in Q4
  localparam logic [DVS_W-1:0] SPEED_DIV = 44'd100000;

  typedef enum logic [1:0] {
    REG_TEETH    = 2'd0,
    REG_TPM      = 2'd1,
    REG_CIRC     = 2'd2,
    REG_TIMEOUT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        new_left;
    logic [31:0] stamp_left_latest;
    logic [31:0] stamp_left_before;
    logic        new_right;
    logic [31:0] stamp_right_latest;
    logic [31:0] stamp_right_before;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rpm_left_q4;
    logic [31:0] rpm_right_q4;
    logic [31:0] speed_kmh_q4;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/wsc_div.sv
// Shared restoring divider, one quotient bit per cycle, 32-bit saturating quotient.
// Depends on wsc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wsc_div import wsc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [Q_W-1:0]        quotient
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [Q_W-1:0]   qr;

  logic [DVS_W-1:0] hi;
  logic             sat;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             take;

  // Quotient fits in 32 bits only if dividend >> 32 is below the divisor
  assign hi  = DVS_W'(dividend[DVD_W-1:Q_W]);
  assign sat = (hi >= divisor);

  // One restoring step
  assign shifted = {rem, qr[Q_W-1]};
  assign take    = (shifted >= {1'b0, divisor});
  assign diff    = shifted - {1'b0, divisor};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (sat) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == {CNT_W{1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      if (sat) begin
        qr <= {Q_W{1'b1}};
      end else begin
        rem <= hi;
        qr  <= dividend[Q_W-1:0];
      end
    end else if (busy) begin
      rem <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      qr  <= {qr[Q_W-2:0], take};
    end
  end

  assign quotient = qr;

  `WSC_ASSERT(a_start_idle, clk, rst, start |-> !busy, "divider started while busy")
  `WSC_ASSERT(a_run_after_start, clk, rst, (start && !sat) |=> (busy && !done),
              "divider did not begin iterating")
  `WSC_ASSERT(a_done_ends_run, clk, rst, done |-> !busy, "done raised while still iterating")

endmodule

`default_nettype wire

// File: rtl/wheel_speed_from_capture.sv
// Wheel speed from tooth capture timestamps: top level with sequencer and state.
// Depends on wsc_pkg, wsc_div and assert_macros.svh.
//
// One poll item in, one result item out. Per wheel with new captures and a
// nonzero in-range tooth interval, the interval is converted to rpm (Q4) by a
// division; the vehicle speed (Q4 km/h) takes one more division. All three
// divisions run on one shared bit-serial divider: a division holds the
// sequencer through its start, 32 steps and hand-off, or only through start and
// hand-off when the quotient saturates. The block takes a new item only when the
// previous one is finished; a finished result waits in the output register while
// the next item is already accepted, and a result that is still waiting there
// holds the sequencer in its last state.
`default_nettype none
`include "assert_macros.svh"

module wheel_speed_from_capture import wsc_pkg::*; #(
  parameter int unsigned STAMP_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Interval arithmetic width: at least the overflow limit
  localparam int unsigned DW = (STAMP_WIDTH > IVAL_W) ? STAMP_WIDTH : IVAL_W;
  localparam logic [DW-1:0] STAMP_MASK = {DW{1'b1}} >> (DW - STAMP_WIDTH);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WHEEL  = 8'b0000_0010,
    S_DSTART = 8'b0000_0100,
    S_DWAIT  = 8'b0000_1000,
    S_SUM    = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_MUL3   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration
  logic [7:0]  teeth_per_turn;
  logic [31:0] ticks_per_minute;
  logic [15:0] wheel_circumference_mm;
  logic [15:0] stop_timeout_polls;

  // Wheel state
  logic [31:0] rpm_left, rpm_right;
  logic [15:0] stall_left, stall_right;

  // Work registers
  in_item_t         item;
  logic             sel;
  logic             div_speed;
  logic [DVS_W-1:0] den;
  logic [DVD_W-1:0] acc;
  logic [31:0]      speed;

  // Divider hookup
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [Q_W-1:0]   div_quot;

  // Selected wheel
  logic        w_flag;
  logic [31:0] w_latest, w_before;
  logic [15:0] w_stall, w_stall_next;
  logic [DW-1:0]     diff_full, ival_masked;
  logic [IVAL_W-1:0] interval;
  logic              ival_over;
  logic [31:0]       ovf_rpm;
  logic [DVS_W-1:0]  den_calc;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      teeth_per_turn         <= 8'd22;
      ticks_per_minute       <= 32'd60000000;
      wheel_circumference_mm <= 16'd1800;
      stop_timeout_polls     <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEETH:   teeth_per_turn         <= cfg_data[7:0];
        REG_TPM:     ticks_per_minute       <= cfg_data;
        REG_CIRC:    wheel_circumference_mm <= cfg_data[15:0];
        REG_TIMEOUT: stop_timeout_polls     <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  // Per-wheel operand select
  assign w_flag   = sel ? item.new_right : item.new_left;
  assign w_latest = sel ? item.stamp_right_latest : item.stamp_left_latest;
  assign w_before = sel ? item.stamp_right_before : item.stamp_left_before;
  assign w_stall  = sel ? stall_right : stall_left;
  assign w_stall_next = (w_stall == 16'hFFFF) ? w_stall : w_stall + 16'd1;

  // Tooth interval modulo 2^STAMP_WIDTH
  assign diff_full   = DW'(w_latest) - DW'(w_before);
  assign ival_masked = diff_full & STAMP_MASK;
  assign ival_over   = ((ival_masked >> IVAL_W) != '0);
  assign interval    = ival_masked[IVAL_W-1:0];
  assign den_calc    = DVS_W'(interval) * DVS_W'(teeth_per_turn);

  // Oversized interval: zero rpm, unless zero teeth makes the divisor zero
  assign ovf_rpm = (teeth_per_turn == 8'd0) ? 32'hFFFF_FFFF : 32'd0;

  // Divider operands
  assign div_start    = (state == S_DSTART);
  assign div_dividend = div_speed ? acc : DVD_W'({ticks_per_minute, 4'b0000});
  assign div_divisor  = div_speed ? SPEED_DIV : den;

  wsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer and wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      sel         <= 1'b0;
      div_speed   <= 1'b0;
      rpm_left    <= '0;
      rpm_right   <= '0;
      stall_left  <= '0;
      stall_right <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sel       <= 1'b0;
            div_speed <= 1'b0;
            state     <= S_WHEEL;
          end
        end
        S_WHEEL: begin
          state <= sel ? S_SUM : S_WHEEL;
          sel   <= 1'b1;
          if (w_flag) begin
            if (sel) stall_right <= '0;
            else     stall_left  <= '0;
            if (ival_over) begin
              if (sel) rpm_right <= ovf_rpm;
              else     rpm_left  <= ovf_rpm;
            end else if (interval != '0) begin
              sel   <= sel;
              state <= S_DSTART;
            end
          end else begin
            if (sel) stall_right <= w_stall_next;
            else     stall_left  <= w_stall_next;
            if (w_stall_next > stop_timeout_polls) begin
              if (sel) rpm_right <= '0;
              else     rpm_left  <= '0;
            end
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            if (div_speed) begin
              state <= S_OUT;
            end else begin
              if (sel) rpm_right <= div_quot;
              else     rpm_left  <= div_quot;
              state <= sel ? S_SUM : S_WHEEL;
              sel   <= 1'b1;
            end
          end
        end
        S_SUM: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_MUL3;
        end
        S_MUL3: begin
          div_speed <= 1'b1;
          state     <= S_DSTART;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item <= in_data;
    end
    if (state == S_WHEEL) begin
      den <= den_calc;
    end
    // Speed: rpm sum, times circumference, times three
    unique case (state)
      S_SUM:   acc <= DVD_W'(rpm_left) + DVD_W'(rpm_right);
      S_MUL:   acc <= DVD_W'(acc[32:0] * 49'(wheel_circumference_mm));
      S_MUL3:  acc <= acc + (acc << 1);
      default: ;
    endcase
    if (state == S_DWAIT && div_done && div_speed) begin
      speed <= div_quot;
    end
    if (state == S_OUT && out_free) begin
      out_data.rpm_left_q4  <= rpm_left;
      out_data.rpm_right_q4 <= rpm_right;
      out_data.speed_kmh_q4 <= speed;
    end
  end

  `WSC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!out_valid && in_ready),
                     "reset did not leave the block empty and idle")
  `WSC_ASSERT(a_accept_busy, clk, rst, (in_valid && in_ready) |=> !in_ready,
              "block still ready after taking an item")
  `WSC_ASSERT(a_done_in_wait, clk, rst, div_done |-> (state == S_DWAIT),
              "divider finished outside the wait state")
  `WSC_ASSERT(a_result_loaded, clk, rst, (state == S_OUT && out_free) |=> (out_valid && in_ready),
              "finished item not presented")

endmodule

`default_nettype wire
